// ----- rtl/core/positional_list_store_macros.svh -----
// Assertion macros for the positional list store.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond holds in the same cycle as trig
`define PLS_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("positional list store: check failed");

// cond holds in the cycle after trig
`define PLS_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("positional list store: check failed");

`else

`define PLS_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define PLS_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

// ----- rtl/core/pls_pkg.sv -----
// Package: types, codes and sizing for the positional list store.
package pls_pkg;

    localparam int CAPACITY = 128;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 8;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;

    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int CAP_IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IDX_W    = (POS_W > CAP_IW) ? POS_W : CAP_IW;
    localparam int CMP_W    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

    // read-out OR tree: cells per first-level group
    localparam int GROUP    = 16;
    localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic [ACT_W-1:0]  ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0]  ACT_READ   = 2'd1;
    localparam logic [ACT_W-1:0]  ACT_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } pls_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
    } pls_rsp_t;

    // broadcast to every cell
    typedef struct packed {
        logic                     shift_up;
        logic                     shift_down;
        logic [IDX_W-1:0]         pos_idx;
        logic signed [WORD_W-1:0] ins_val;
    } pls_ctrl_t;

endpackage

// ----- rtl/core/pls_cell.sv -----
// One list slot: holds a word, shifts with its neighbors, taps out on a read hit.
module pls_cell (
    input  logic                             clk,
    input  pls_pkg::pls_ctrl_t               ctrl,
    input  logic [pls_pkg::IDX_W-1:0]        idx,
    input  logic signed [pls_pkg::WORD_W-1:0] prev_word,
    input  logic signed [pls_pkg::WORD_W-1:0] next_word,
    output logic signed [pls_pkg::WORD_W-1:0] word,
    output logic signed [pls_pkg::WORD_W-1:0] tap
);

    logic signed [pls_pkg::WORD_W-1:0] word_reg;
    logic signed [pls_pkg::WORD_W-1:0] word_next;
    logic                              hit;
    logic                              after;

    assign hit   = (idx == ctrl.pos_idx);
    assign after = (idx > ctrl.pos_idx);

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.shift_up)
        begin
            if (hit)
            begin
                word_next = ctrl.ins_val;
            end
            else if (after)
            begin
                word_next = prev_word;
            end
        end
        else if (ctrl.shift_down && (hit || after))
        begin
            word_next = next_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    assign tap  = hit ? word_reg : '0;

endmodule

// ----- rtl/core/positional_list_store.sv -----
// Positional list store: a row of cells holding an ordered list of signed words.
// An item is accepted at a rising edge where start is high and busy is low. For insert,
// delete and any rejected item, every cell compares its own index with the position
// and shifts in the same edge, and the result appears with done in the next cycle while
// busy stays low, so such items can be issued back to back. A successful read passes
// the hit cell's word through a registered OR tree over all cells (groups of 16, then
// one final level), and busy is high for the one cycle in which the tree resolves. Each
// result is on rsp for exactly one cycle, marked by done; the receiver cannot hold it
// off and must take it then.
module positional_list_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pls_pkg::pls_cmd_t cmd,
    output logic              done,
    output pls_pkg::pls_rsp_t rsp
);

`include "positional_list_store_macros.svh"

    logic                             accept;
    logic [pls_pkg::CMP_W-1:0]        pos_w;
    logic [pls_pkg::CMP_W-1:0]        len_w;
    logic                             pos_nz;
    logic                             ins_ok;
    logic                             ins_full;
    logic                             rd_ok;
    logic                             do_insert;
    logic                             do_delete;
    logic                             do_read;
    logic [pls_pkg::STAT_W-1:0]       status;
    pls_pkg::pls_ctrl_t               ctrl;

    logic [pls_pkg::LEN_W-1:0]        len_reg;
    logic [pls_pkg::LEN_W-1:0]        len_next;
    logic                             pend_reg;
    logic                             done_reg;
    pls_pkg::pls_rsp_t                rsp_reg;

    logic signed [pls_pkg::WORD_W-1:0] words [pls_pkg::CAPACITY];
    logic signed [pls_pkg::WORD_W-1:0] taps  [pls_pkg::CAPACITY];
    logic signed [pls_pkg::WORD_W-1:0] part_next [pls_pkg::NGROUPS];
    logic signed [pls_pkg::WORD_W-1:0] part_reg  [pls_pkg::NGROUPS];
    logic signed [pls_pkg::WORD_W-1:0] rd_word;

    assign accept = start && !busy;
    assign busy   = pend_reg;

    // position checks
    assign pos_w    = pls_pkg::CMP_W'(cmd.position);
    assign len_w    = pls_pkg::CMP_W'(len_reg);
    assign pos_nz   = (cmd.position != '0);
    assign ins_ok   = pos_nz && (pos_w <= len_w + pls_pkg::CMP_W'(1));
    assign ins_full = (len_reg == pls_pkg::LEN_W'(pls_pkg::CAPACITY));
    assign rd_ok    = pos_nz && (pos_w <= len_w);

    always_comb
    begin
        do_insert = 1'b0;
        do_delete = 1'b0;
        do_read   = 1'b0;
        status    = pls_pkg::ST_BAD_POS;
        unique case (cmd.action)
            pls_pkg::ACT_INSERT:
            begin
                if (ins_ok)
                begin
                    if (ins_full)
                    begin
                        status = pls_pkg::ST_FULL;
                    end
                    else
                    begin
                        status    = pls_pkg::ST_OK;
                        do_insert = 1'b1;
                    end
                end
            end
            pls_pkg::ACT_READ:
            begin
                if (rd_ok)
                begin
                    status  = pls_pkg::ST_OK;
                    do_read = 1'b1;
                end
            end
            pls_pkg::ACT_DELETE:
            begin
                if (rd_ok)
                begin
                    status    = pls_pkg::ST_OK;
                    do_delete = 1'b1;
                end
            end
            default:
            begin
                status = pls_pkg::ST_BAD_POS;
            end
        endcase
    end

    always_comb
    begin
        len_next = len_reg;
        if (accept && do_insert)
        begin
            len_next = len_reg + pls_pkg::LEN_W'(1);
        end
        else if (accept && do_delete)
        begin
            len_next = len_reg - pls_pkg::LEN_W'(1);
        end
    end

    assign ctrl.shift_up   = accept && do_insert;
    assign ctrl.shift_down = accept && do_delete;
    assign ctrl.pos_idx    = pls_pkg::IDX_W'(cmd.position) - pls_pkg::IDX_W'(1);
    assign ctrl.ins_val    = cmd.value;

    // the row of cells
    for (genvar i = 0; i < pls_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [pls_pkg::WORD_W-1:0] prev_w;
        logic signed [pls_pkg::WORD_W-1:0] next_w;

        if (i == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_mid_lo
            assign prev_w = words[i-1];
        end

        if (i == pls_pkg::CAPACITY - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_mid_hi
            assign next_w = words[i+1];
        end

        pls_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .idx       (pls_pkg::IDX_W'(i)),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (words[i]),
            .tap       (taps[i])
        );
    end

    // first level of the read-out tree
    always_comb
    begin
        for (int g = 0; g < pls_pkg::NGROUPS; g++)
        begin
            part_next[g] = '0;
            for (int j = 0; j < pls_pkg::GROUP; j++)
            begin
                if (g * pls_pkg::GROUP + j < pls_pkg::CAPACITY)
                begin
                    part_next[g] = part_next[g] | taps[g * pls_pkg::GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && do_read)
        begin
            for (int g = 0; g < pls_pkg::NGROUPS; g++)
            begin
                part_reg[g] <= part_next[g];
            end
        end
    end

    always_comb
    begin
        rd_word = '0;
        for (int g = 0; g < pls_pkg::NGROUPS; g++)
        begin
            rd_word = rd_word | part_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            pend_reg <= accept && do_read;
            done_reg <= pend_reg || (accept && !do_read);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            rsp_reg.status     <= pls_pkg::ST_OK;
            rsp_reg.read_value <= rd_word;
            rsp_reg.count      <= pls_pkg::COUNT_W'(len_reg);
        end
        else if (accept)
        begin
            rsp_reg.status     <= status;
            rsp_reg.read_value <= '0;
            rsp_reg.count      <= pls_pkg::COUNT_W'(len_next);
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // every accepted transaction gives a result next cycle or holds the block busy
    `PLS_ASSERT_NEXT(a_accept_answers, clk, rst_n, accept, done || busy)
    // a read in flight finishes in the next cycle and frees the block
    `PLS_ASSERT_NEXT(a_read_one_cycle, clk, rst_n, busy, done && !busy)
    // a successful insert grows the list by exactly one
    `PLS_ASSERT_NEXT(a_insert_grows, clk, rst_n, accept && do_insert, len_reg == $past(len_reg) + pls_pkg::LEN_W'(1))
    // a failed transaction never reports data
    `PLS_ASSERT_SAME(a_fail_no_data, clk, rst_n, done && (rsp.status != pls_pkg::ST_OK), rsp.read_value == '0)
    // length never exceeds the capacity
    `PLS_ASSERT_SAME(a_len_bound, clk, rst_n, 1'b1, len_reg <= pls_pkg::LEN_W'(pls_pkg::CAPACITY))

endmodule
